// ===== rtl/nrrw_pkg.sv =====
package nrrw_pkg;

  localparam int unsigned RING_BYTES_DEF   = 16384;
  localparam int unsigned WINDOW_BYTES_DEF = 16400;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;

  localparam logic [10:0] MAX_FRAME_RST = 11'd1514;
  localparam logic [15:0] CRC_BYTES     = 16'd4;
  localparam logic [16:0] HDR_BYTES     = 17'd4;
  localparam logic [15:0] CAPR_BIAS     = 16'd16;

  localparam logic [1:0] VERDICT_GOOD    = 2'd0;
  localparam logic [1:0] VERDICT_FLAGS   = 2'd1;
  localparam logic [1:0] VERDICT_LEN_ERR = 2'd2;

  // header after classification, handed from front to back
  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] stored_len;
    logic [10:0] payload_len;
  } class_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [10:0] payload_len;
    logic [14:0] payload_start;
    logic [10:0] first_count;
    logic [10:0] second_count;
    logic        capr_write;
    logic [15:0] capr_value;
    logic [14:0] next_offset;
  } result_t;

endpackage

// ===== rtl/nrrw_fifo.sv =====
module nrrw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/nrrw_front.sv =====
module nrrw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [4:0]          in_error_flags,
  input  logic [15:0]         in_stored_len,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [10:0]         cfg_data,
  input  logic                mid_full,
  output logic                mid_push,
  output nrrw_pkg::class_t    mid_item
);
  import nrrw_pkg::*;

  logic [10:0] max_frame_r;
  logic [15:0] pkt_len;
  logic        len_bad;

  assign cfg_ready = 1'b1;
  assign in_full   = mid_full;
  assign mid_push  = in_push && !mid_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= MAX_FRAME_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_frame_r <= cfg_data;
    end
  end

  assign pkt_len = in_stored_len - CRC_BYTES;
  assign len_bad = (in_stored_len < CRC_BYTES) || (pkt_len >= {5'd0, max_frame_r});

  // flag errors take priority over length errors
  always_comb begin
    mid_item.stored_len  = in_stored_len;
    mid_item.payload_len = pkt_len[10:0];
    if (in_error_flags != 5'd0) begin
      mid_item.verdict = VERDICT_FLAGS;
    end else if (len_bad) begin
      mid_item.verdict = VERDICT_LEN_ERR;
    end else begin
      mid_item.verdict = VERDICT_GOOD;
    end
  end

endmodule

// ===== rtl/nrrw_back.sv =====
module nrrw_back #(
  parameter int unsigned RING_BYTES   = nrrw_pkg::RING_BYTES_DEF,
  parameter int unsigned WINDOW_BYTES = nrrw_pkg::WINDOW_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mid_empty,
  output logic                mid_pop,
  input  nrrw_pkg::class_t    mid_item,
  input  logic                res_full,
  output logic                res_push,
  output nrrw_pkg::result_t   res_item
);
  import nrrw_pkg::*;

  localparam logic [16:0] RingW = 17'(RING_BYTES);
  localparam logic [16:0] WinW  = 17'(WINDOW_BYTES);

  logic [14:0] read_offset_r, read_offset_nxt;
  logic [16:0] curr_ext, end_sum, lim, first_raw, adv, next_full;
  logic [10:0] first_cnt, second_cnt;
  logic [14:0] next_off;
  logic        good;

  assign mid_pop  = !mid_empty && !res_full;
  assign res_push = mid_pop;
  assign good     = (mid_item.verdict == VERDICT_GOOD);

  always_comb begin
    curr_ext  = {2'd0, read_offset_r};
    end_sum   = curr_ext + {1'b0, mid_item.stored_len};
    lim       = curr_ext + HDR_BYTES;
    first_raw = (lim >= WinW) ? 17'd0 : (WinW - lim);
    if (end_sum > WinW) begin
      first_cnt  = (first_raw > {6'd0, mid_item.payload_len}) ?
                   mid_item.payload_len : first_raw[10:0];
      second_cnt = mid_item.payload_len - first_cnt;
    end else begin
      first_cnt  = mid_item.payload_len;
      second_cnt = 11'd0;
    end
    adv       = (end_sum + HDR_BYTES + 17'd3) & ~17'd3;
    next_full = (adv > RingW) ? (adv - RingW) : adv;
    next_off  = next_full[14:0];
  end

  always_comb begin
    res_item = '0;
    res_item.verdict = mid_item.verdict;
    if (good) begin
      res_item.payload_len   = mid_item.payload_len;
      res_item.payload_start = read_offset_r + 15'(HDR_BYTES);
      res_item.first_count   = first_cnt;
      res_item.second_count  = second_cnt;
      res_item.capr_write    = 1'b1;
      res_item.capr_value    = {1'b0, next_off} - CAPR_BIAS;
      res_item.next_offset   = next_off;
    end
  end

  always_comb begin
    read_offset_nxt = read_offset_r;
    if (mid_pop) begin
      read_offset_nxt = good ? next_off : 15'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_offset_r <= '0;
    end else begin
      read_offset_r <= read_offset_nxt;
    end
  end

endmodule

// ===== rtl/nic_rx_ring_walker_unit.sv =====
// Receive-ring read-pointer walker. Each transaction on the in_ side is one
// packet header (error flags and stored length including CRC); each out_
// transaction is its verdict, payload length/start, window split counts, the
// new CAPR value and the next ring offset. An error resets the ring offset to
// zero and gives no CAPR write. One header is taken per clock while in_full
// is low: a front stage classifies the header against max_frame_len, a short
// queue decouples it from the back stage, which updates the single offset
// register, and a result queue holds outputs so that in_full only rises after
// both queues fill under out_pop backpressure. max_frame_len is written
// through cfg_data/cfg_valid (cfg_ready stays high); the user must write it
// only while no transaction is in flight, which the block does not enforce.
module nic_rx_ring_walker_unit #(
  parameter int unsigned RING_BYTES   = nrrw_pkg::RING_BYTES_DEF,
  parameter int unsigned WINDOW_BYTES = nrrw_pkg::WINDOW_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH  = nrrw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [4:0]  in_error_flags,
  input  logic [15:0] in_stored_len,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_verdict,
  output logic [10:0] out_payload_len,
  output logic [14:0] out_payload_start,
  output logic [10:0] out_first_count,
  output logic [10:0] out_second_count,
  output logic        out_capr_write,
  output logic [15:0] out_capr_value,
  output logic [14:0] out_next_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);
  import nrrw_pkg::*;

  class_t  mid_wr, mid_rd;
  result_t res_wr, res_rd;
  logic    mid_push, mid_full, mid_pop, mid_empty;
  logic    res_push, res_full;

  nrrw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_error_flags (in_error_flags),
    .in_stored_len  (in_stored_len),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mid_full       (mid_full),
    .mid_push       (mid_push),
    .mid_item       (mid_wr)
  );

  nrrw_fifo #(
    .WIDTH ($bits(class_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wr),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rd),
    .empty (mid_empty)
  );

  nrrw_back #(
    .RING_BYTES   (RING_BYTES),
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_item  (mid_rd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_wr)
  );

  nrrw_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wr),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rd),
    .empty (out_empty)
  );

  assign out_verdict       = res_rd.verdict;
  assign out_payload_len   = res_rd.payload_len;
  assign out_payload_start = res_rd.payload_start;
  assign out_first_count   = res_rd.first_count;
  assign out_second_count  = res_rd.second_count;
  assign out_capr_write    = res_rd.capr_write;
  assign out_capr_value    = res_rd.capr_value;
  assign out_next_offset   = res_rd.next_offset;

endmodule
